### hw/rtl/ccb_pkg.sv
// ----------------------------------------------------------------------------
// ccb_pkg
// Shared types and constants of the cascaded comb blend unit: configuration
// register indexes, datapath widths and the control word of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package ccb_pkg;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;

	localparam logic [CFG_IDX_W-1:0] CFG_DELAY_WHOLE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DELAY_FRAC    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_GAIN = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MIX_AMOUNT    = 2'd3;

	localparam logic [15:0] DELAY_WHOLE_RST = 16'd100;

	// Item fields
	localparam int CHANNEL_W = 2;

	// Datapath widths
	localparam int WORD_W    = 32;              // stored comb values, Q8.23
	localparam int COEF_W    = 17;              // Q1.16 coefficients up to one
	localparam int OPB_W     = COEF_W + 1;      // coefficient as a signed operand
	localparam int PROD_W    = WORD_W + OPB_W;
	localparam int ACC_W     = 52;
	localparam int ACC_SHIFT = 16;
	localparam int HI_W      = ACC_W - ACC_SHIFT;

	localparam logic [COEF_W-1:0] UNITY = 17'd65536;

	// Sequencer
	localparam int STEP_W = 5;

	typedef enum logic [1:0] {
		J_NEXT,
		J_WAIT_IN,
		J_WAIT_OUT
	} jump_t;

	typedef enum logic [1:0] {
		A_RD,
		A_T,
		A_X
	} asel_t;

	typedef enum logic [2:0] {
		B_FRAC_INV,
		B_FRAC,
		B_FB,
		B_FB_INV,
		B_MIX_INV,
		B_MIX
	} bsel_t;

	typedef enum logic [2:0] {
		ACC_KEEP,
		ACC_LOAD,
		ACC_ADD,
		ACC_INIT_X,
		ACC_INIT_H
	} acc_op_t;

	typedef enum logic [1:0] {
		T_KEEP,
		T_SHIFT,
		T_SAT32
	} t_op_t;

	typedef enum logic [1:0] {
		OUT_NONE,
		OUT_BLEND,
		OUT_PASS
	} out_op_t;

	typedef struct packed {
		jump_t              jump;
		logic [STEP_W-1:0]  target;
		logic               rd_en;
		logic               rd_store;   // 0: first comb, 1: second comb
		logic               rd_tap;     // 0: nearer tap, 1: farther tap
		logic               wr_en;
		logic               wr_store;
		asel_t              asel;
		bsel_t              bsel;
		logic               mul_en;
		acc_op_t            acc_op;
		t_op_t              t_op;
		logic               hold_en;
		logic               wp_inc;
		out_op_t            out_op;
	} ctrl_word_t;

	typedef struct packed {
		logic item_acc;
		logic item_pass;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

### hw/rtl/ccb_if.sv
// ----------------------------------------------------------------------------
// ccb_if
// Valid/ready channels of the cascaded comb blend unit: the sample input
// channel and the sample output channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface ccb_in_if #(
	parameter int SAMPLE_BITS = 24
);
	logic                                valid;
	logic                                ready;
	logic [ccb_pkg::CHANNEL_W-1:0]       channel;
	logic signed [SAMPLE_BITS-1:0]       sample_in;

	modport source (output valid, output channel, output sample_in, input ready);
	modport sink (input valid, input channel, input sample_in, output ready);
endinterface

interface ccb_out_if #(
	parameter int SAMPLE_BITS = 24
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

### hw/rtl/ccb_ram.sv
// ----------------------------------------------------------------------------
// ccb_ram
// Simple dual-port memory: one write port, one read port with registered
// read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ccb_ram #(
	parameter int DEPTH = 131072,
	parameter int WIDTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### hw/rtl/ccb_datapath.sv
// ----------------------------------------------------------------------------
// ccb_datapath
// Datapath of the cascaded comb blend unit: configuration registers, item
// capture, delay-line memories with fill tracking, one shared multiplier with
// accumulator, saturation and the output register. Driven by a control word.
// ----------------------------------------------------------------------------
`default_nettype none

module ccb_datapath #(
	parameter int DELAY_DEPTH = 65536,
	parameter int SAMPLE_BITS = 24
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [ccb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [ccb_pkg::CFG_DATA_W-1:0]   cfg_data,
	ccb_in_if.sink                                din,
	ccb_out_if.source                             dout,
	input  ccb_pkg::ctrl_word_t                   cw,
	output ccb_pkg::status_t                      stat
);

	localparam int PW        = $clog2(DELAY_DEPTH);
	localparam int MEM_DEPTH = 2 * DELAY_DEPTH;
	localparam int AW        = $clog2(MEM_DEPTH);
	localparam int CW        = ((PW > 16) ? PW : 16) + 1;
	localparam int WW        = ccb_pkg::WORD_W;
	localparam int HW        = ccb_pkg::HI_W;

	localparam logic [CW-1:0]        D_MIN      = CW'(1);
	localparam logic [CW-1:0]        D_MAX      = CW'(DELAY_DEPTH - 2);
	localparam logic [PW:0]          DEPTH_X    = (PW + 1)'(DELAY_DEPTH);
	localparam logic [PW-1:0]        WP_LAST    = PW'(DELAY_DEPTH - 1);
	localparam logic [AW-1:0]        CH1_BASE   = AW'(DELAY_DEPTH);
	localparam logic signed [HW-1:0] ONE_S      = HW'(1);
	localparam logic signed [HW-1:0] W_MAX      = (ONE_S <<< (WW - 1)) - ONE_S;
	localparam logic signed [HW-1:0] W_MIN      = -W_MAX - ONE_S;
	localparam logic signed [HW-1:0] S_MAX      = (ONE_S <<< (SAMPLE_BITS - 1)) - ONE_S;
	localparam logic signed [HW-1:0] S_MIN      = -S_MAX - ONE_S;

	// Configuration registers
	logic [15:0]                     delay_whole_q;
	logic [15:0]                     delay_frac_q;
	logic [15:0]                     feedback_gain_q;
	logic [ccb_pkg::COEF_W-1:0]      mix_amount_q;

	// Per-channel write pointers and wrap flags
	logic [PW-1:0]                   wp_tab_q [2];
	logic                            wrap_q [2];

	// Item registers
	logic signed [SAMPLE_BITS-1:0]   x_q;
	logic                            ch_q;
	logic [PW-1:0]                   wp_cur_q;
	logic [PW-1:0]                   d_q;

	// Arithmetic registers
	logic                            rd_valid_q;
	logic                            rd_store_q;
	logic signed [ccb_pkg::PROD_W-1:0] prod_q;
	logic signed [ccb_pkg::ACC_W-1:0]  acc_q;
	logic signed [WW-1:0]            t_q;
	logic signed [WW-1:0]            h_q;

	// Output register
	logic                            out_valid_q;
	logic signed [SAMPLE_BITS-1:0]   out_data_q;

	logic                            item_acc;
	logic                            out_free;
	logic [CW-1:0]                   d_ext;
	logic [PW-1:0]                   d_clamp;
	logic [ccb_pkg::COEF_W-1:0]      mix_c;
	logic [ccb_pkg::COEF_W-1:0]      b_val;
	logic [PW:0]                     sub1;
	logic [PW:0]                     sub2;
	logic [PW-1:0]                   r1;
	logic [PW-1:0]                   r2;
	logic [PW-1:0]                   rd_idx;
	logic [AW-1:0]                   base;
	logic [AW-1:0]                   rd_addr;
	logic [AW-1:0]                   wr_addr;
	logic                            rd_valid_d;
	logic [WW-1:0]                   rdata1;
	logic [WW-1:0]                   rdata2;
	logic signed [WW-1:0]            rd_word;
	logic signed [WW-1:0]            a_op;
	logic signed [ccb_pkg::OPB_W-1:0] b_op;
	logic signed [ccb_pkg::PROD_W-1:0] prod_d;
	logic signed [WW+ccb_pkg::ACC_SHIFT-1:0] x_shl;
	logic signed [WW+ccb_pkg::ACC_SHIFT-1:0] h_shl;
	logic signed [HW-1:0]            acc_hi;
	logic signed [HW-1:0]            sat_w;
	logic signed [HW-1:0]            sat_s;
	logic [PW-1:0]                   wp_next;

	assign item_acc  = din.valid && din.ready;
	assign out_free  = !out_valid_q || dout.ready;
	assign din.ready = (cw.jump == ccb_pkg::J_WAIT_IN);

	assign stat.item_acc  = item_acc;
	assign stat.item_pass = din.channel[1];
	assign stat.out_free  = out_free;

	assign dout.valid      = out_valid_q;
	assign dout.sample_out = out_data_q;

	// Delay clamp to 1..DELAY_DEPTH-2
	always_comb begin
		d_ext = CW'(delay_whole_q);
		if (d_ext < D_MIN) begin
			d_clamp = PW'(D_MIN);
		end else if (d_ext > D_MAX) begin
			d_clamp = PW'(D_MAX);
		end else begin
			d_clamp = PW'(d_ext);
		end
	end

	assign mix_c = (mix_amount_q > ccb_pkg::UNITY) ? ccb_pkg::UNITY : mix_amount_q;

	// Tap positions behind the write pointer, wrapped into the line.
	assign sub1 = {1'b0, wp_cur_q} - {1'b0, d_q};
	assign sub2 = sub1 - (PW + 1)'(1);
	assign r1   = sub1[PW] ? PW'(sub1 + DEPTH_X) : PW'(sub1);
	assign r2   = sub2[PW] ? PW'(sub2 + DEPTH_X) : PW'(sub2);

	assign rd_idx  = cw.rd_tap ? r2 : r1;
	assign base    = ch_q ? CH1_BASE : AW'(0);
	assign rd_addr = AW'(rd_idx) + base;
	assign wr_addr = AW'(wp_cur_q) + base;

	// Until a line has wrapped once, only the entries below the write
	// pointer have been written; the others still read as zero.
	assign rd_valid_d = wrap_q[ch_q] || (rd_idx < wp_cur_q);

	ccb_ram #(
		.DEPTH (MEM_DEPTH),
		.WIDTH (WW)
	) u_ram_first (
		.clk   (clk),
		.we    (cw.wr_en && !cw.wr_store),
		.waddr (wr_addr),
		.wdata (t_q),
		.re    (cw.rd_en && !cw.rd_store),
		.raddr (rd_addr),
		.rdata (rdata1)
	);

	ccb_ram #(
		.DEPTH (MEM_DEPTH),
		.WIDTH (WW)
	) u_ram_second (
		.clk   (clk),
		.we    (cw.wr_en && cw.wr_store),
		.waddr (wr_addr),
		.wdata (t_q),
		.re    (cw.rd_en && cw.rd_store),
		.raddr (rd_addr),
		.rdata (rdata2)
	);

	assign rd_word = rd_valid_q ? (rd_store_q ? rdata2 : rdata1) : '0;

	always_comb begin
		case (cw.asel)
			ccb_pkg::A_RD: a_op = rd_word;
			ccb_pkg::A_T:  a_op = t_q;
			ccb_pkg::A_X:  a_op = WW'(x_q);
			default:       a_op = '0;
		endcase
	end

	always_comb begin
		case (cw.bsel)
			ccb_pkg::B_FRAC_INV: b_val = ccb_pkg::UNITY - {1'b0, delay_frac_q};
			ccb_pkg::B_FRAC:     b_val = {1'b0, delay_frac_q};
			ccb_pkg::B_FB:       b_val = {1'b0, feedback_gain_q};
			ccb_pkg::B_FB_INV:   b_val = ccb_pkg::UNITY - {1'b0, feedback_gain_q};
			ccb_pkg::B_MIX_INV:  b_val = ccb_pkg::UNITY - mix_c;
			ccb_pkg::B_MIX:      b_val = mix_c;
			default:             b_val = '0;
		endcase
	end

	assign b_op   = {1'b0, b_val};
	assign prod_d = a_op * b_op;
	assign x_shl  = {WW'(x_q), {ccb_pkg::ACC_SHIFT{1'b0}}};
	assign h_shl  = {h_q, {ccb_pkg::ACC_SHIFT{1'b0}}};

	// The arithmetic shift of the accumulator is the floor of the division.
	assign acc_hi = acc_q[ccb_pkg::ACC_W-1:ccb_pkg::ACC_SHIFT];

	always_comb begin
		if (acc_hi > W_MAX) begin
			sat_w = W_MAX;
		end else if (acc_hi < W_MIN) begin
			sat_w = W_MIN;
		end else begin
			sat_w = acc_hi;
		end
		if (acc_hi > S_MAX) begin
			sat_s = S_MAX;
		end else if (acc_hi < S_MIN) begin
			sat_s = S_MIN;
		end else begin
			sat_s = acc_hi;
		end
	end

	assign wp_next = (wp_cur_q == WP_LAST) ? '0 : wp_cur_q + PW'(1);

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_whole_q   <= ccb_pkg::DELAY_WHOLE_RST;
			delay_frac_q    <= '0;
			feedback_gain_q <= '0;
			mix_amount_q    <= '0;
			wp_tab_q[0]     <= '0;
			wp_tab_q[1]     <= '0;
			wrap_q[0]       <= 1'b0;
			wrap_q[1]       <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					ccb_pkg::CFG_DELAY_WHOLE:   delay_whole_q   <= cfg_data[15:0];
					ccb_pkg::CFG_DELAY_FRAC:    delay_frac_q    <= cfg_data[15:0];
					ccb_pkg::CFG_FEEDBACK_GAIN: feedback_gain_q <= cfg_data[15:0];
					ccb_pkg::CFG_MIX_AMOUNT:    mix_amount_q    <= cfg_data;
				endcase
			end
			if (cw.wp_inc) begin
				wp_tab_q[ch_q] <= wp_next;
				if (wp_cur_q == WP_LAST) begin
					wrap_q[ch_q] <= 1'b1;
				end
			end
			if ((cw.out_op != ccb_pkg::OUT_NONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (dout.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (item_acc) begin
			x_q      <= din.sample_in;
			ch_q     <= din.channel[0];
			wp_cur_q <= wp_tab_q[din.channel[0]];
			d_q      <= d_clamp;
		end
		if (cw.rd_en) begin
			rd_valid_q <= rd_valid_d;
			rd_store_q <= cw.rd_store;
		end
		if (cw.mul_en) begin
			prod_q <= prod_d;
		end
		case (cw.acc_op)
			ccb_pkg::ACC_LOAD:   acc_q <= ccb_pkg::ACC_W'(prod_q);
			ccb_pkg::ACC_ADD:    acc_q <= acc_q + ccb_pkg::ACC_W'(prod_q);
			ccb_pkg::ACC_INIT_X: acc_q <= ccb_pkg::ACC_W'(x_shl);
			ccb_pkg::ACC_INIT_H: acc_q <= ccb_pkg::ACC_W'(h_shl);
			default:             acc_q <= acc_q;
		endcase
		case (cw.t_op)
			ccb_pkg::T_SHIFT: t_q <= WW'(acc_hi);
			ccb_pkg::T_SAT32: t_q <= WW'(sat_w);
			default:          t_q <= t_q;
		endcase
		if (cw.hold_en) begin
			h_q <= t_q;
		end
		if (out_free) begin
			case (cw.out_op)
				ccb_pkg::OUT_BLEND: out_data_q <= SAMPLE_BITS'(sat_s);
				ccb_pkg::OUT_PASS:  out_data_q <= x_q;
				default:            out_data_q <= out_data_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### hw/rtl/ccb_sequencer.sv
// ----------------------------------------------------------------------------
// ccb_sequencer
// Microprogram store and step counter. Each step issues one control word to
// the datapath; waiting steps hold until their handshake condition is met.
// ----------------------------------------------------------------------------
`default_nettype none

module ccb_sequencer (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  ccb_pkg::status_t    stat,
	output ccb_pkg::ctrl_word_t cw
);

	localparam int SW = ccb_pkg::STEP_W;

	localparam logic [SW-1:0] STEP_IDLE = SW'(0);
	localparam logic [SW-1:0] STEP_PASS = SW'(23);

	logic [SW-1:0] step_q;

	function automatic ccb_pkg::ctrl_word_t program_word(input logic [SW-1:0] step);
		ccb_pkg::ctrl_word_t w;
		w        = '0;
		w.jump   = ccb_pkg::J_NEXT;
		w.target = STEP_IDLE;
		w.asel   = ccb_pkg::A_RD;
		w.bsel   = ccb_pkg::B_FRAC_INV;
		w.acc_op = ccb_pkg::ACC_KEEP;
		w.t_op   = ccb_pkg::T_KEEP;
		w.out_op = ccb_pkg::OUT_NONE;
		case (step)
			// Wait for an item; pass-through channels branch off.
			STEP_IDLE: begin
				w.jump   = ccb_pkg::J_WAIT_IN;
				w.target = STEP_PASS;
			end
			// First comb: interpolate the two taps.
			SW'(1): begin
				w.rd_en = 1'b1;
			end
			SW'(2): begin
				w.rd_en  = 1'b1;
				w.rd_tap = 1'b1;
				w.mul_en = 1'b1;
				w.bsel   = ccb_pkg::B_FRAC_INV;
			end
			SW'(3): begin
				w.mul_en = 1'b1;
				w.bsel   = ccb_pkg::B_FRAC;
				w.acc_op = ccb_pkg::ACC_LOAD;
			end
			SW'(4): w.acc_op = ccb_pkg::ACC_ADD;
			SW'(5): w.t_op   = ccb_pkg::T_SHIFT;
			// First comb: feedback and sum.
			SW'(6): begin
				w.mul_en = 1'b1;
				w.asel   = ccb_pkg::A_T;
				w.bsel   = ccb_pkg::B_FB;
				w.acc_op = ccb_pkg::ACC_INIT_X;
			end
			SW'(7): w.acc_op = ccb_pkg::ACC_ADD;
			SW'(8): w.t_op   = ccb_pkg::T_SAT32;
			// Store the first comb result and start the second comb.
			SW'(9): begin
				w.wr_en    = 1'b1;
				w.hold_en  = 1'b1;
				w.rd_en    = 1'b1;
				w.rd_store = 1'b1;
			end
			SW'(10): begin
				w.rd_en    = 1'b1;
				w.rd_store = 1'b1;
				w.rd_tap   = 1'b1;
				w.mul_en   = 1'b1;
				w.bsel     = ccb_pkg::B_FRAC_INV;
			end
			SW'(11): begin
				w.mul_en = 1'b1;
				w.bsel   = ccb_pkg::B_FRAC;
				w.acc_op = ccb_pkg::ACC_LOAD;
			end
			SW'(12): w.acc_op = ccb_pkg::ACC_ADD;
			SW'(13): w.t_op   = ccb_pkg::T_SHIFT;
			SW'(14): begin
				w.mul_en = 1'b1;
				w.asel   = ccb_pkg::A_T;
				w.bsel   = ccb_pkg::B_FB;
				w.acc_op = ccb_pkg::ACC_INIT_H;
			end
			SW'(15): w.acc_op = ccb_pkg::ACC_ADD;
			SW'(16): w.t_op   = ccb_pkg::T_SAT32;
			// Store the second comb result, advance the pointer, scale.
			SW'(17): begin
				w.wr_en    = 1'b1;
				w.wr_store = 1'b1;
				w.wp_inc   = 1'b1;
				w.mul_en   = 1'b1;
				w.asel     = ccb_pkg::A_T;
				w.bsel     = ccb_pkg::B_FB_INV;
			end
			SW'(18): w.acc_op = ccb_pkg::ACC_LOAD;
			// Blend wet and dry.
			SW'(19): begin
				w.t_op   = ccb_pkg::T_SHIFT;
				w.mul_en = 1'b1;
				w.asel   = ccb_pkg::A_X;
				w.bsel   = ccb_pkg::B_MIX_INV;
			end
			SW'(20): begin
				w.mul_en = 1'b1;
				w.asel   = ccb_pkg::A_T;
				w.bsel   = ccb_pkg::B_MIX;
				w.acc_op = ccb_pkg::ACC_LOAD;
			end
			SW'(21): w.acc_op = ccb_pkg::ACC_ADD;
			SW'(22): begin
				w.out_op = ccb_pkg::OUT_BLEND;
				w.jump   = ccb_pkg::J_WAIT_OUT;
				w.target = STEP_IDLE;
			end
			STEP_PASS: begin
				w.out_op = ccb_pkg::OUT_PASS;
				w.jump   = ccb_pkg::J_WAIT_OUT;
				w.target = STEP_IDLE;
			end
			default: begin
				w.jump   = ccb_pkg::J_WAIT_OUT;
				w.target = STEP_IDLE;
			end
		endcase
		return w;
	endfunction

	assign cw = program_word(step_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
		end else begin
			case (cw.jump)
				ccb_pkg::J_NEXT: step_q <= step_q + SW'(1);
				ccb_pkg::J_WAIT_IN: begin
					if (stat.item_acc) begin
						step_q <= stat.item_pass ? cw.target : step_q + SW'(1);
					end
				end
				ccb_pkg::J_WAIT_OUT: begin
					if (stat.out_free) begin
						step_q <= cw.target;
					end
				end
				default: step_q <= STEP_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

### hw/rtl/cascaded_comb_blend_unit.sv
// ----------------------------------------------------------------------------
// cascaded_comb_blend_unit
// Two feedback comb filters with fractional delay in cascade, blended with
// the dry input. Channels 0 and 1 are filtered, channels 2 and 3 pass through.
//
// Usage:
// - din carries one item per valid/ready handshake: channel and sample_in.
//   dout carries one sample_out per item, in order.
// - Configuration is written through cfg_we/cfg_index/cfg_data while no item
//   is in flight: delay_whole, delay_frac, feedback_gain, mix_amount.
// - A filtered item runs through the microprogram before reaching the output
//   register, a pass-through item through a single pass step; the shared
//   multiplier and one delay-line read per step set the length of the former.
//   Items are handled one at a time; din.ready is high only in the wait step.
// - A result waits in the output register while dout stalls; the next item
//   is accepted and processed meanwhile, and the sequencer holds at its final
//   step until the output register is free.
// - Reset restores the sequencer, pointers, configuration and output valid.
//   Delay lines read as zero until written, tracked per channel by the write
//   pointer and a wrap flag, so there is no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module cascaded_comb_blend_unit #(
	parameter int DELAY_DEPTH = 65536,
	parameter int SAMPLE_BITS = 24
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [ccb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [ccb_pkg::CFG_DATA_W-1:0]   cfg_data,
	ccb_in_if.sink                                din,
	ccb_out_if.source                             dout
);

	ccb_pkg::ctrl_word_t cw;
	ccb_pkg::status_t    stat;

	ccb_sequencer u_sequencer (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cw     (cw)
	);

	ccb_datapath #(
		.DELAY_DEPTH (DELAY_DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.din       (din),
		.dout      (dout),
		.cw        (cw),
		.stat      (stat)
	);

endmodule

`default_nettype wire

### hw/rtl/ccb_checker.sv
// ----------------------------------------------------------------------------
// ccb_checker
// Port-level checks of the cascaded comb blend unit, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module ccb_checker #(
	parameter int SAMPLE_BITS = 24
) (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                in_valid,
	input wire logic                                in_ready,
	input wire logic [ccb_pkg::CHANNEL_W-1:0]       in_channel,
	input wire logic signed [SAMPLE_BITS-1:0]       in_sample,
	input wire logic                                out_valid,
	input wire logic                                out_ready,
	input wire logic signed [SAMPLE_BITS-1:0]       out_sample
);

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output item dropped while stalled");

	// Items are handled one at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item accepted while one is in work");

	// A pass-through item into an empty output register shows up unchanged, via
	// the item register and then the output register, loaded in the pass step.
	a_pass_through: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_channel[1] && !out_valid |->
		##2 (out_valid && (out_sample == $past(in_sample, 2))))
		else $error("pass-through item wrong or late");

	// Loading a result returns the sequencer to the wait step.
	a_ready_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("not ready for a new item after a result");

endmodule

bind cascaded_comb_blend_unit ccb_checker #(
	.SAMPLE_BITS (SAMPLE_BITS)
) u_ccb_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (din.valid),
	.in_ready   (din.ready),
	.in_channel (din.channel),
	.in_sample  (din.sample_in),
	.out_valid  (dout.valid),
	.out_ready  (dout.ready),
	.out_sample (dout.sample_out)
);

`default_nettype wire

### bench/ccb_blend_checker.sv
// ----------------------------------------------------------------------------
// ccb_blend_checker
// Watches the configuration port and both sample channels of the cascaded
// comb blend unit. A bit-exact predictor keeps its own delay lines, write
// pointers and register copies, queues the expected sample_out of every
// accepted item and compares each output item against the oldest one.
// ----------------------------------------------------------------------------
module ccb_blend_checker
	import ccb_pkg::*;
#(
	parameter int SAMPLE_BITS = 24
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	ccb_in_if                          din,
	ccb_out_if                         dout,
	output int                         errors,
	output int                         pending,
	output int                         filtered,
	output int                         out_clipped,
	output int                         sum_clipped
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PTR_W = 16;
	localparam int LINE_LEN = 1 << PTR_W;
	localparam longint WORD_MAX = 64'sd2147483647;
	localparam longint WORD_MIN = -64'sd2147483648;
	localparam longint SAMPLE_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
	localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
	localparam int REPORT_CAP = 20;

	typedef struct {
		int unsigned                   seq;
		logic [CHANNEL_W-1:0]          channel;
		logic signed [SAMPLE_BITS-1:0] sample_out;
	} blend_expect_t;

	blend_expect_t blend_q[$];
	blend_expect_t head;
	int line_mem [2][2][LINE_LEN];   // [comb stage][channel][position]
	logic [PTR_W-1:0] wr_ptr [2];
	logic [15:0] delay_whole;
	logic [15:0] delay_frac;
	logic [15:0] feedback_gain;
	logic [COEF_W-1:0] mix_amount;
	int unsigned item_seq;

	// One comb stage: interpolate between the taps at dly and dly+1 behind wp,
	// add the feedback and store the saturated sum at wp.
	function automatic longint comb_pass(int stage, int chan, logic [PTR_W-1:0] wp,
			logic [PTR_W-1:0] dly, longint x);
		logic [PTR_W-1:0] near_pos;
		logic [PTR_W-1:0] far_pos;
		longint near_tap;
		longint far_tap;
		longint tap;
		longint sum;
		near_pos = wp - dly;
		far_pos = near_pos - 1'b1;
		near_tap = line_mem[stage][chan][near_pos];
		far_tap = line_mem[stage][chan][far_pos];
		tap = (near_tap * (longint'(UNITY) - longint'(delay_frac)) +
			far_tap * longint'(delay_frac)) >>> ACC_SHIFT;
		sum = x + ((tap * longint'(feedback_gain)) >>> ACC_SHIFT);
		if (sum > WORD_MAX) begin
			sum = WORD_MAX;
			sum_clipped++;
		end else if (sum < WORD_MIN) begin
			sum = WORD_MIN;
			sum_clipped++;
		end
		line_mem[stage][chan][wp] = int'(sum);
		return sum;
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] blend_sample(
			logic [CHANNEL_W-1:0] ch, logic signed [SAMPLE_BITS-1:0] dry);
		logic [PTR_W-1:0] dly;
		logic [PTR_W-1:0] wp;
		longint x;
		longint first_y;
		longint second_y;
		longint wet;
		longint mix;
		longint mixed;
		// Channels 2 and 3 bypass the filter and leave all state alone.
		if (ch[1])
			return dry;
		x = dry;
		dly = delay_whole;
		if (delay_whole == 0)
			dly = 1;
		else if (delay_whole > LINE_LEN - 2)
			dly = LINE_LEN - 2;
		wp = wr_ptr[ch[0]];
		first_y = comb_pass(0, ch[0], wp, dly, x);
		second_y = comb_pass(1, ch[0], wp, dly, first_y);
		wr_ptr[ch[0]] = wp + 1'b1;
		mix = (mix_amount > UNITY) ? longint'(UNITY) : longint'(mix_amount);
		wet = (second_y * (longint'(UNITY) - longint'(feedback_gain))) >>> ACC_SHIFT;
		mixed = (x * (longint'(UNITY) - mix) + wet * mix) >>> ACC_SHIFT;
		if (mixed > SAMPLE_MAX) begin
			mixed = SAMPLE_MAX;
			out_clipped++;
		end else if (mixed < SAMPLE_MIN) begin
			mixed = SAMPLE_MIN;
			out_clipped++;
		end
		filtered++;
		return mixed[SAMPLE_BITS-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_whole = DELAY_WHOLE_RST;
			delay_frac = '0;
			feedback_gain = '0;
			mix_amount = '0;
			wr_ptr[0] = '0;
			wr_ptr[1] = '0;
			item_seq = 0;
			errors = 0;
			pending = 0;
			filtered = 0;
			out_clipped = 0;
			sum_clipped = 0;
		end else begin
			// An output item always belongs to an earlier input item, so it is
			// matched before this edge's input item is queued.
			if (dout.valid && dout.ready) begin
				if (blend_q.size() == 0) begin
					errors++;
					if (errors <= REPORT_CAP)
						$display("%0t: sample_out %0d arrived with no item outstanding",
							$time, dout.sample_out);
				end else begin
					head = blend_q.pop_front();
					if (dout.sample_out !== head.sample_out) begin
						errors++;
						if (errors <= REPORT_CAP)
							$display("%0t: item %0d on channel %0d: sample_out expected %0d, got %0d",
								$time, head.seq, head.channel, head.sample_out,
								dout.sample_out);
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_DELAY_WHOLE: delay_whole = cfg_data[15:0];
					CFG_DELAY_FRAC: delay_frac = cfg_data[15:0];
					CFG_FEEDBACK_GAIN: feedback_gain = cfg_data[15:0];
					CFG_MIX_AMOUNT: mix_amount = cfg_data[COEF_W-1:0];
					default: ;
				endcase
			end
			if (din.valid && din.ready) begin
				head.seq = item_seq;
				head.channel = din.channel;
				head.sample_out = blend_sample(din.channel, din.sample_in);
				blend_q.push_back(head);
				item_seq++;
			end
			pending = blend_q.size();
		end
	end

endmodule

### bench/cascaded_comb_blend_unit_tb.sv
// ----------------------------------------------------------------------------
// cascaded_comb_blend_unit_tb
// Stimulus for the cascaded comb blend unit. A short directed part hits the
// register extremes, the pass-through channels, delay clamping, mix above
// one and both kinds of saturation; then random phases with fresh settings
// send random samples while both channels idle at random. The checker beside
// the block predicts every result; this module reports the verdict.
// ----------------------------------------------------------------------------
module cascaded_comb_blend_unit_tb;
	import ccb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SAMPLE_BITS = 24;
	localparam int LIMIT = 1_000_000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS = 230;
	localparam int CALM_PHASE = 2;
	localparam int RESONANT_PHASE = 5;
	localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic calm;
	int sent_count;
	int results_seen;
	int settings_count;
	int cycle_count;
	int errors;
	int pending;
	int filtered;
	int out_clipped;
	int sum_clipped;

	ccb_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) din_if ();
	ccb_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) dout_if ();

	cascaded_comb_blend_unit #(.SAMPLE_BITS(SAMPLE_BITS)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.din(din_if),
		.dout(dout_if)
	);

	ccb_blend_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.din(din_if),
		.dout(dout_if),
		.errors(errors),
		.pending(pending),
		.filtered(filtered),
		.out_clipped(out_clipped),
		.sum_clipped(sum_clipped)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (dout_if.valid && dout_if.ready)
			results_seen <= results_seen + 1;
		if (cycle_count >= LIMIT) begin
			$display("cascaded_comb_blend_unit test failed");
			$finish;
		end
	end

	// Output side: bursts of ready, short stalls and now and then a long one.
	initial begin : rx_side
		int hold;
		int roll;
		hold = 0;
		dout_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (calm)
				dout_if.ready <= 1'b1;
			else if (hold > 0)
				hold--;
			else begin
				roll = $urandom_range(0, 99);
				if (roll < 65) begin
					dout_if.ready <= 1'b1;
					hold = $urandom_range(0, 7);
				end else if (roll < 94) begin
					dout_if.ready <= 1'b0;
					hold = $urandom_range(0, 3);
				end else begin
					dout_if.ready <= 1'b0;
					hold = $urandom_range(15, 60);
				end
			end
		end
	end

	task automatic write_settings(input logic [15:0] dw, input logic [15:0] df,
			input logic [15:0] fb, input logic [CFG_DATA_W-1:0] mx);
		cfg_we <= 1'b1;
		cfg_index <= CFG_DELAY_WHOLE;
		cfg_data <= CFG_DATA_W'(dw);
		@(posedge clk);
		cfg_index <= CFG_DELAY_FRAC;
		cfg_data <= CFG_DATA_W'(df);
		@(posedge clk);
		cfg_index <= CFG_FEEDBACK_GAIN;
		cfg_data <= CFG_DATA_W'(fb);
		@(posedge clk);
		cfg_index <= CFG_MIX_AMOUNT;
		cfg_data <= mx;
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_count++;
	endtask

	// Called at a clock edge; returns at the edge where the next item may start.
	task automatic send_item(input logic [CHANNEL_W-1:0] ch,
			input logic signed [SAMPLE_BITS-1:0] s);
		int gap;
		int roll;
		din_if.valid <= 1'b1;
		din_if.channel <= ch;
		din_if.sample_in <= s;
		do
			@(posedge clk);
		while (!din_if.ready);
		sent_count++;
		roll = $urandom_range(0, 99);
		if (calm || roll < 55)
			gap = 0;
		else if (roll < 92)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(12, 40);
		if (gap > 0) begin
			din_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		din_if.valid <= 1'b0;
		while (results_seen != sent_count)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	initial begin
		int ph;
		int n;
		int roll;
		logic [CHANNEL_W-1:0] ch;
		logic signed [SAMPLE_BITS-1:0] s;
		logic [15:0] dw;
		logic [15:0] df;
		logic [15:0] fb;
		logic [CFG_DATA_W-1:0] mx;

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_DELAY_WHOLE;
		cfg_data <= '0;
		din_if.valid <= 1'b0;
		din_if.channel <= '0;
		din_if.sample_in <= '0;
		calm <= 1'b0;
		sent_count = 0;
		settings_count = 0;
		results_seen <= 0;
		cycle_count <= 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset settings: pass-through on both bypass channels, dry output.
		send_item(2, S_MAX);
		send_item(3, S_MIN);
		send_item(0, S_MAX);
		send_item(1, S_MIN);
		send_item(0, '0);
		wait_idle();

		// Delay of zero clamps to one; half feedback drives the output into
		// saturation on both signs.
		write_settings(16'd0, 16'hFFFF, 16'h8000, UNITY);
		repeat (8) send_item(0, S_MAX);
		send_item(3, '1);
		repeat (4) send_item(1, S_MIN);
		wait_idle();

		// Longest delay clamps to the far end of the line; mix above one.
		write_settings(16'hFFFF, 16'd0, 16'hFFFF, {CFG_DATA_W{1'b1}});
		send_item(1, S_MAX);
		send_item(0, S_MIN);
		send_item(2, 24'sd1);
		send_item(0, '1);
		send_item(1, 24'sh2AAAAA);
		wait_idle();

		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			roll = $urandom_range(0, 9);
			if (roll == 0)
				dw = 16'd0;
			else if (roll == 1)
				dw = 16'hFFFF;
			else if (roll == 2)
				dw = 16'hFFFE;
			else if (roll < 7)
				dw = $urandom_range(1, 8);
			else if (roll < 9)
				dw = $urandom_range(9, 300);
			else
				dw = $urandom_range(1, 65535);
			roll = $urandom_range(0, 5);
			df = (roll == 0) ? 16'd0 : (roll == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
			roll = $urandom_range(0, 5);
			if (roll == 0)
				fb = 16'd0;
			else if (roll == 1)
				fb = 16'hFFFF;
			else if (roll == 2)
				fb = 16'd64880;
			else
				fb = $urandom_range(0, 65535);
			roll = $urandom_range(0, 5);
			if (roll == 0)
				mx = '0;
			else if (roll == 1)
				mx = UNITY;
			else if (roll == 2)
				mx = {CFG_DATA_W{1'b1}};
			else
				mx = $urandom_range(0, 131071);
			// A short loop at full feedback fed with large positive samples
			// pushes the stored comb sums into saturation.
			if (ph == RESONANT_PHASE) begin
				dw = 16'd1;
				fb = 16'hFFFF;
			end
			write_settings(dw, df, fb, mx);
			calm <= (ph == CALM_PHASE);

			for (n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 79) == 0)
					wait_idle();
				roll = $urandom_range(0, 99);
				ch = (roll < 40) ? 2'd0 : (roll < 80) ? 2'd1 : (roll < 90) ? 2'd2 : 2'd3;
				roll = $urandom_range(0, 99);
				if (roll < 4)
					s = S_MAX;
				else if (roll < 8)
					s = S_MIN;
				else if (roll < 12)
					s = '1;
				else if (roll < 15)
					s = '0;
				else if (roll < 40)
					s = $urandom_range(0, 4095) - 2048;
				else
					s = $urandom();
				if (ph == RESONANT_PHASE && !ch[1])
					s = $urandom_range(4194304, 8388607);
				send_item(ch, s);
			end
			wait_idle();
			calm <= 1'b0;
		end

		repeat (30) @(posedge clk);
		$display("Sent %0d items, %0d of them through the combs, under %0d register settings.",
			sent_count, filtered, settings_count);
		$display("Saturation struck %0d stored comb sums and %0d output samples.",
			sum_clipped, out_clipped);
		if (errors == 0 && pending == 0)
			$display("cascaded_comb_blend_unit test passed");
		else
			$display("cascaded_comb_blend_unit test failed");
		$finish;
	end

endmodule

### cascaded_comb_blend_unit.f
hw/rtl/ccb_pkg.sv
hw/rtl/ccb_if.sv
hw/rtl/ccb_ram.sv
hw/rtl/ccb_datapath.sv
hw/rtl/ccb_sequencer.sv
hw/rtl/cascaded_comb_blend_unit.sv
hw/rtl/ccb_checker.sv
bench/ccb_blend_checker.sv
bench/cascaded_comb_blend_unit_tb.sv
